// ----- rtl/core/pcsha_pkg.sv -----
// Shared types and constants for the pc sample hash aggregator.
// Holds the transaction structs, opcode and status codes, and write-enable bundle.
// No dependencies.
package pcsha_pkg;

  localparam int BUFFER_SIZE_DEF = 1024;
  localparam int HASH_SIZE_DEF   = 2048;
  localparam int EVENT_COUNT_DEF = 6;

  localparam int IO_EVENTS = 6;
  localparam int PC_SHIFT  = 4;
  localparam logic [7:0] HIT_MAX = 8'd255;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int STAT_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_MERGED  = 3'd0,
    ST_ADDED   = 3'd1,
    ST_FULL    = 3'd2,
    ST_DROPPED = 3'd3,
    ST_READ    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [63:0]        pc;
    logic [INDEX_W-1:0] index;
    logic signed [63:0] event_0;
    logic signed [63:0] event_1;
    logic signed [63:0] event_2;
    logic signed [63:0] event_3;
    logic signed [63:0] event_4;
    logic signed [63:0] event_5;
  } sample_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
    logic [63:0]        entry_pc;
    logic [7:0]         sample_count;
    logic signed [63:0] sum_0;
    logic signed [63:0] sum_1;
    logic signed [63:0] sum_2;
    logic signed [63:0] sum_3;
    logic signed [63:0] sum_4;
    logic signed [63:0] sum_5;
    logic [63:0]        range_low;
    logic [63:0]        range_high;
  } result_t;

  typedef struct packed {
    logic pc_we;
    logic hit_we;
    logic ev_we;
  } store_we_t;

endpackage

// ----- rtl/core/pcsha_store.sv -----
// Entry storage: address, hit count and event-sum memories.
// Uses pcsha_pkg for the write-enable bundle. Registered reads.
module pcsha_store import pcsha_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF,
  parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
  input  logic                      clk,
  input  store_we_t                 we,
  input  logic [$clog2(BUFFER_SIZE)-1:0] waddr,
  input  logic [$clog2(BUFFER_SIZE)-1:0] raddr,
  input  logic [63:0]               pc_wdata,
  input  logic [7:0]                hit_wdata,
  input  logic [$clog2(BUFFER_SIZE)+((EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1)-1:0] ev_addr,
  input  logic [63:0]               ev_wdata,
  output logic [63:0]               pc_rdata,
  output logic [7:0]                hit_rdata,
  output logic [63:0]               ev_rdata
);

  localparam int LW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int EV_DEPTH = BUFFER_SIZE << LW;

  logic [63:0] pc_mem  [BUFFER_SIZE];
  logic [7:0]  hit_mem [BUFFER_SIZE];
  logic [63:0] ev_mem  [EV_DEPTH];

  always_ff @(posedge clk) begin
    if (we.pc_we) begin
      pc_mem[waddr] <= pc_wdata;
    end
    pc_rdata <= pc_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.hit_we) begin
      hit_mem[waddr] <= hit_wdata;
    end
    hit_rdata <= hit_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.ev_we) begin
      ev_mem[ev_addr] <= ev_wdata;
    end
    ev_rdata <= ev_mem[ev_addr];
  end

endmodule

// ----- rtl/core/pc_sample_hash_aggregator_unit.sv -----
// Top level of the pc sample hash aggregator: sequencer, bucket table, shared adder.
// Depends on pcsha_pkg and pcsha_store.
//
//   channel | signals                                     | payload
//   --------+---------------------------------------------+---------
//   sample  | sample_valid, sample_ready, sample          | sample_t
//   result  | result_valid, result_ready, result          | result_t
//
// One transaction at a time. Add: probe, check, match states per probed bucket, then
// read, add states per event lane; a bit-serial pc hash first if HASH_SIZE is not a
// power of two. Read: read, add states per event lane. Clear, and reset, sweep the
// bucket table at one bucket per cycle; sample_ready stays low during the sweep. A
// finished result waits in the output register while the next transaction is accepted.
module pc_sample_hash_aggregator_unit import pcsha_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF,
  parameter int HASH_SIZE   = HASH_SIZE_DEF,
  parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int EW = $clog2(BUFFER_SIZE);
  localparam int FW = $clog2(BUFFER_SIZE + 1);
  localparam int HW = $clog2(HASH_SIZE);
  localparam int PW = $clog2(HASH_SIZE + 1);
  localparam int LW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam bit HASH_POW2 = ((HASH_SIZE & (HASH_SIZE - 1)) == 0);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLEAR  = 10'b0000000010,
    S_HASH   = 10'b0000000100,
    S_PROBE  = 10'b0000001000,
    S_CHECK  = 10'b0000010000,
    S_MATCH  = 10'b0000100000,
    S_APPEND = 10'b0001000000,
    S_EV_RD  = 10'b0010000000,
    S_EV_ADD = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t        state;
  func_t         op;
  status_t       status;
  logic [63:0]   pc_q;
  logic [63:0]   ev_q  [IO_EVENTS];
  logic [63:0]   sum_q [IO_EVENTS];
  logic [HW-1:0] bucket;
  logic [HW-1:0] clr_idx;
  logic [PW-1:0] probe_cnt;
  logic [HW:0]   hash_r;
  logic [5:0]    hash_bit;
  logic [EW-1:0] entry;
  logic [LW-1:0] lane;
  logic [FW-1:0] fill_level;
  logic [63:0]   low_q;
  logic [63:0]   high_q;
  logic          merge;
  logic          rd_ok;
  logic          clr_resp;

  logic [FW-1:0] bkt_mem [HASH_SIZE];
  logic [FW-1:0] bkt_rdata;
  logic          bkt_we;
  logic [HW-1:0] bkt_waddr;
  logic [FW-1:0] bkt_wdata;

  store_we_t     st_we;
  logic [EW-1:0] st_waddr;
  logic [EW-1:0] st_raddr;
  logic [7:0]    hit_wdata;
  logic [63:0]   pc_rdata;
  logic [7:0]    hit_rdata;
  logic [63:0]   ev_rdata;
  logic [63:0]   ev_lane;
  logic [63:0]   acc;
  logic [2:0]    lane3;
  logic [HW:0]   hash_shift;
  logic [HW:0]   hash_next;
  logic [HW-1:0] bucket_next;
  logic          read_in_range;
  logic          lane_last;
  logic          bkt_empty;

  assign sample_ready = (state == S_IDLE);

  assign lane3     = 3'(lane);
  assign ev_lane   = (lane3 < 3'(IO_EVENTS)) ? ev_q[lane3] : 64'd0;
  assign acc       = (merge ? ev_rdata : 64'd0) + ev_lane;
  assign lane_last = (lane == LW'(EVENT_COUNT - 1));

  assign hash_shift = {hash_r[HW-1:0], pc_q[hash_bit]};
  assign hash_next  = (hash_shift >= (HW+1)'(HASH_SIZE)) ?
                      hash_shift - (HW+1)'(HASH_SIZE) : hash_shift;
  assign bucket_next = (bucket == HW'(HASH_SIZE - 1)) ? '0 : bucket + 1'b1;
  assign read_in_range = (32'(sample.index) < 32'(fill_level));
  assign bkt_empty = (bkt_rdata == '0) || (32'(bkt_rdata) > 32'(BUFFER_SIZE));

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = bucket;
    bkt_wdata = FW'(fill_level + 1'b1);
    st_we     = '0;
    st_waddr  = entry;
    hit_wdata = hit_rdata + 8'd1;
    st_raddr  = (state == S_CHECK) ? EW'(bkt_rdata - 1'b1) : entry;
    case (state)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_idx;
        bkt_wdata = '0;
      end
      S_MATCH: begin
        st_we.hit_we = (pc_rdata == pc_q) && (hit_rdata < HIT_MAX);
      end
      S_APPEND: begin
        if (32'(fill_level) < 32'(BUFFER_SIZE)) begin
          bkt_we       = 1'b1;
          st_we.pc_we  = 1'b1;
          st_we.hit_we = 1'b1;
          st_waddr     = EW'(fill_level);
          hit_wdata    = 8'd1;
        end
      end
      S_EV_ADD: begin
        st_we.ev_we = (op != FN_READ);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata <= bkt_mem[bucket];
  end

  pcsha_store #(
    .BUFFER_SIZE(BUFFER_SIZE),
    .EVENT_COUNT(EVENT_COUNT)
  ) u_store (
    .clk      (clk),
    .we       (st_we),
    .waddr    (st_waddr),
    .raddr    (st_raddr),
    .pc_wdata (pc_q),
    .hit_wdata(hit_wdata),
    .ev_addr  ({entry, lane}),
    .ev_wdata (acc),
    .pc_rdata (pc_rdata),
    .hit_rdata(hit_rdata),
    .ev_rdata (ev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      clr_resp     <= 1'b0;
      fill_level   <= '0;
      low_q        <= '1;
      high_q       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            op    <= func_t'(sample.func);
            rd_ok <= 1'b0;
            merge <= 1'b0;
            for (int i = 0; i < IO_EVENTS; i++) begin
              sum_q[i] <= '0;
            end
            case (func_t'(sample.func))
              FN_ADD: begin
                pc_q      <= sample.pc;
                ev_q[0]   <= sample.event_0;
                ev_q[1]   <= sample.event_1;
                ev_q[2]   <= sample.event_2;
                ev_q[3]   <= sample.event_3;
                ev_q[4]   <= sample.event_4;
                ev_q[5]   <= sample.event_5;
                probe_cnt <= '0;
                hash_r    <= '0;
                hash_bit  <= 6'd63;
                if (HASH_POW2) begin
                  bucket <= sample.pc[PC_SHIFT +: HW];
                  state  <= S_PROBE;
                end else begin
                  state  <= S_HASH;
                end
              end
              FN_READ: begin
                status <= ST_READ;
                lane   <= '0;
                entry  <= EW'(sample.index);
                if (read_in_range) begin
                  rd_ok <= 1'b1;
                  state <= S_EV_RD;
                end else begin
                  state <= S_EMIT;
                end
              end
              FN_CLEAR: begin
                status     <= ST_CLEARED;
                fill_level <= '0;
                low_q      <= '1;
                high_q     <= '0;
                clr_idx    <= '0;
                clr_resp   <= 1'b1;
                state      <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_idx == HW'(HASH_SIZE - 1)) begin
            state <= clr_resp ? S_EMIT : S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_HASH: begin
          hash_r <= hash_next;
          if (hash_bit == 6'(PC_SHIFT)) begin
            bucket <= HW'(hash_next);
            state  <= S_PROBE;
          end else begin
            hash_bit <= hash_bit - 1'b1;
          end
        end
        S_PROBE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (bkt_empty) begin
            state <= S_APPEND;
          end else begin
            entry <= EW'(bkt_rdata - 1'b1);
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (pc_rdata == pc_q) begin
            if (hit_rdata < HIT_MAX) begin
              merge  <= 1'b1;
              lane   <= '0;
              status <= ST_MERGED;
              state  <= S_EV_RD;
            end else begin
              state <= S_APPEND;
            end
          end else if (probe_cnt == PW'(HASH_SIZE - 1)) begin
            status <= ST_DROPPED;
            state  <= S_EMIT;
          end else begin
            probe_cnt <= probe_cnt + 1'b1;
            bucket    <= bucket_next;
            state     <= S_PROBE;
          end
        end
        S_APPEND: begin
          if (32'(fill_level) >= 32'(BUFFER_SIZE)) begin
            status <= ST_DROPPED;
            state  <= S_EMIT;
          end else begin
            entry      <= EW'(fill_level);
            fill_level <= fill_level + 1'b1;
            if (pc_q < low_q) begin
              low_q <= pc_q;
            end
            if (pc_q > high_q) begin
              high_q <= pc_q;
            end
            status <= (32'(fill_level) + 1 == BUFFER_SIZE) ? ST_FULL : ST_ADDED;
            merge  <= 1'b0;
            lane   <= '0;
            state  <= S_EV_RD;
          end
        end
        S_EV_RD: begin
          state <= S_EV_ADD;
        end
        S_EV_ADD: begin
          if (op == FN_READ && lane3 < 3'(IO_EVENTS)) begin
            sum_q[lane3] <= ev_rdata;
          end
          if (lane_last) begin
            state <= S_EMIT;
          end else begin
            lane  <= lane + 1'b1;
            state <= S_EV_RD;
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result.status       <= status;
            result.entry_count  <= COUNT_W'(fill_level);
            result.entry_pc     <= rd_ok ? pc_rdata : 64'd0;
            result.sample_count <= rd_ok ? hit_rdata : 8'd0;
            result.sum_0        <= sum_q[0];
            result.sum_1        <= sum_q[1];
            result.sum_2        <= sum_q[2];
            result.sum_3        <= sum_q[3];
            result.sum_4        <= sum_q[4];
            result.sum_5        <= sum_q[5];
            result.range_low    <= low_q;
            result.range_high   <= high_q;
            clr_resp            <= 1'b0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/pc_sample_hash_aggregator_checker.sv -----
// Checker for the pc sample hash aggregator: watches both channels, predicts each result.
// Keeps its own bucket table and entry stores; needs pcsha_pkg.
`timescale 1ns / 100ps
module pc_sample_hash_aggregator_checker import pcsha_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  input  logic    sample_ready,
  input  sample_t sample,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      errors,
  output int      pending
);

  localparam int NBUF  = BUFFER_SIZE_DEF;
  localparam int NHASH = HASH_SIZE_DEF;

  logic [COUNT_W-1:0] bucket_ptr [NHASH];
  logic [63:0]        entry_addr [NBUF];
  logic [7:0]         entry_hits [NBUF];
  logic [63:0]        entry_sums [NBUF][IO_EVENTS];
  logic [COUNT_W-1:0] fill;
  logic [63:0]        addr_lo, addr_hi;
  result_t            results_due[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", what, got, want));
  endtask

  function automatic void empty_buckets();
    foreach (bucket_ptr[i]) bucket_ptr[i] = '0;
    fill = '0;
    addr_lo = '1;
    addr_hi = '0;
  endfunction

  function automatic status_t aggregate(sample_t s);
    logic [63:0] ev [IO_EVENTS];
    int unsigned bkt;
    int unsigned ptr;
    int unsigned e;
    bit hit_slot;
    ev = '{s.event_0, s.event_1, s.event_2, s.event_3, s.event_4, s.event_5};
    bkt = (s.pc >> PC_SHIFT) % NHASH;
    hit_slot = 0;
    for (int n = 0; n < NHASH; n++) begin
      ptr = bucket_ptr[bkt];
      if (ptr == 0 || ptr > NBUF) begin
        hit_slot = 1;
        break;
      end
      if (entry_addr[ptr-1] == s.pc) begin
        if (entry_hits[ptr-1] < HIT_MAX) begin
          entry_hits[ptr-1]++;
          for (int k = 0; k < EVENT_COUNT_DEF; k++)
            entry_sums[ptr-1][k] += ev[k];
          return ST_MERGED;
        end
        hit_slot = 1;
        break;
      end
      bkt = (bkt + 1) % NHASH;
    end
    if (!hit_slot || fill >= NBUF) return ST_DROPPED;
    e = fill;
    entry_addr[e] = s.pc;
    entry_hits[e] = 8'd1;
    for (int k = 0; k < IO_EVENTS; k++)
      entry_sums[e][k] = (k < EVENT_COUNT_DEF) ? ev[k] : '0;
    fill++;
    if (s.pc < addr_lo) addr_lo = s.pc;
    if (s.pc > addr_hi) addr_hi = s.pc;
    bucket_ptr[bkt] = COUNT_W'(e + 1);
    return (fill == NBUF) ? ST_FULL : ST_ADDED;
  endfunction

  function automatic result_t predict_result(sample_t s);
    result_t r;
    int unsigned idx;
    r = '0;
    case (func_t'(s.func))
      FN_ADD: r.status = aggregate(s);
      FN_READ: begin
        r.status = ST_READ;
        idx = s.index;
        if (idx < fill) begin
          r.entry_pc = entry_addr[idx];
          r.sample_count = entry_hits[idx];
          r.sum_0 = entry_sums[idx][0];
          r.sum_1 = entry_sums[idx][1];
          r.sum_2 = entry_sums[idx][2];
          r.sum_3 = entry_sums[idx][3];
          r.sum_4 = entry_sums[idx][4];
          r.sum_5 = entry_sums[idx][5];
        end
      end
      default: begin
        empty_buckets();
        r.status = ST_CLEARED;
      end
    endcase
    r.entry_count = fill;
    r.range_low = addr_lo;
    r.range_high = addr_hi;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      empty_buckets();
      results_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          want = results_due.pop_front();
          check_field("status", result.status, want.status);
          check_field("entry_count", result.entry_count, want.entry_count);
          check_field("entry_pc", result.entry_pc, want.entry_pc);
          check_field("sample_count", result.sample_count, want.sample_count);
          check_field("sum_0", result.sum_0, want.sum_0);
          check_field("sum_1", result.sum_1, want.sum_1);
          check_field("sum_2", result.sum_2, want.sum_2);
          check_field("sum_3", result.sum_3, want.sum_3);
          check_field("sum_4", result.sum_4, want.sum_4);
          check_field("sum_5", result.sum_5, want.sum_5);
          check_field("range_low", result.range_low, want.range_low);
          check_field("range_high", result.range_high, want.range_high);
        end
      end
      if (sample_valid && sample_ready && func_t'(sample.func) != FN_NONE)
        results_due.push_back(predict_result(sample));
    end
    pending = results_due.size();
  end

endmodule

// ----- dv/pc_sample_hash_aggregator_unit_test.sv -----
// Testbench top for the pc sample hash aggregator: clock, reset, stimulus and verdict.
// Depends on pcsha_pkg, pc_sample_hash_aggregator_unit and pc_sample_hash_aggregator_checker.
`timescale 1ns / 100ps
module pc_sample_hash_aggregator_unit_test;
  import pcsha_pkg::*;

  localparam int STALL_LIMIT = 40000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  int      errors;
  int      pending;
  bit      gaps = 1;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  logic [63:0] pc_pool [16];

  pc_sample_hash_aggregator_unit i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  pc_sample_hash_aggregator_checker i_checker (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (gaps && $urandom_range(0, 4) == 0) begin
      result_ready <= 1'b0;
      hold_left <= $urandom_range(0, 4);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("pc_sample_hash_aggregator_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(sample_t s);
    if (gaps && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic add_pc(logic [63:0] pc, logic [63:0] ev);
    sample_t s;
    s = '0;
    s.func = FN_ADD;
    s.pc = pc;
    s.event_0 = ev;
    s.event_1 = ~ev;
    s.event_2 = rand64();
    s.event_3 = rand64();
    s.event_4 = rand64();
    s.event_5 = rand64();
    send(s);
  endtask

  task automatic op(func_t f, logic [INDEX_W-1:0] idx);
    sample_t s;
    s = '0;
    s.func = f;
    s.index = idx;
    s.pc = rand64();
    s.event_0 = rand64();
    send(s);
  endtask

  task automatic random_item();
    sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    s = '0;
    s.func = FN_ADD;
    s.pc = rand64();
    s.index = INDEX_W'($urandom_range(0, 63));
    s.event_0 = rand64();
    s.event_1 = rand64();
    s.event_2 = rand64();
    s.event_3 = rand64();
    s.event_4 = rand64();
    s.event_5 = rand64();
    if (pick < 55)
      s.pc = pc_pool[$urandom_range(0, 15)] ^ (64'($urandom_range(0, 3)) << 15);
    else if (pick < 78)
      s.func = FN_READ;
    else if (pick < 81)
      s.func = FN_CLEAR;
    else if (pick < 84)
      s.func = FN_NONE;
    send(s);
  endtask

  initial begin
    logic [63:0] hot;
    foreach (pc_pool[i]) pc_pool[i] = rand64();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, merges, bucket collisions, reads, clear
    add_pc(64'h0, 64'h7fff_ffff_ffff_ffff);
    add_pc('1, 64'h8000_0000_0000_0000);
    add_pc(64'h0, 64'h7fff_ffff_ffff_ffff);
    add_pc(64'h0, 64'h1);
    add_pc(64'h0 ^ (64'h1 << 15), 64'hffff_ffff_ffff_ffff);
    add_pc(64'h8000_0000_0000_0010, 64'h0);
    add_pc(64'h7fff_ffff_ffff_fff0, 64'h5555_aaaa_5555_aaaa);
    op(FN_READ, 10'd0);
    op(FN_READ, 10'd1);
    op(FN_READ, 10'd2);
    op(FN_READ, 10'd4);
    op(FN_READ, 10'd1023);
    op(FN_NONE, 10'd0);
    op(FN_CLEAR, 10'd0);
    op(FN_READ, 10'd0);
    add_pc(64'h1234_5678_9abc_def0, 64'h2);
    op(FN_READ, 10'd0);

    // saturated entry: 255 hits, then a new entry for the same address
    hot = rand64();
    repeat (257) add_pc(hot, rand64());
    op(FN_READ, 10'd1);
    op(FN_READ, 10'd2);

    repeat (80) random_item();

    // drain everything before continuing
    sample_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    gaps = 0;
    op(FN_CLEAR, 10'd0);
    repeat (40) random_item();
    sample_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("pc_sample_hash_aggregator_unit test passed");
    end else begin
      $display("pc_sample_hash_aggregator_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pcsha_pkg.sv
rtl/core/pcsha_store.sv
rtl/core/pc_sample_hash_aggregator_unit.sv
dv/pc_sample_hash_aggregator_checker.sv
dv/pc_sample_hash_aggregator_unit_test.sv
